@@ design/dqt_pkg.sv @@
// Shared constants, state type and corner tables of the depth quad triangulator.
package dqt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF     = 3'd6;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [23:0] RST_INV_FOCAL_X  = 24'd33554;
    localparam logic [23:0] RST_INV_FOCAL_Y  = 24'd33554;
    localparam logic [23:0] RST_INV_WIDTH    = 24'd26214;
    localparam logic [23:0] RST_INV_HEIGHT   = 24'd34953;
    localparam logic [15:0] RST_MAX_DIFF     = 16'd3277;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_RADIUS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_EDGE, S_PICK, S_MUL1, S_MUL2, S_RND,
        S_SQR, S_SUM, S_ROOT, S_EMIT
    } t_state;

    // corner j of the triangle opposite corner t
    function automatic logic [1:0] tri_corner(input logic [1:0] t, input logic [1:0] j);
        logic [1:0] c;
        c = 2'd0;
        unique case (t)
            2'd0: c = (j == 2'd0) ? 2'd3 : (j == 2'd1) ? 2'd1 : 2'd2;
            2'd1: c = (j == 2'd0) ? 2'd0 : (j == 2'd1) ? 2'd2 : 2'd3;
            2'd2: c = (j == 2'd0) ? 2'd3 : (j == 2'd1) ? 2'd1 : 2'd0;
            default: c = (j == 2'd0) ? 2'd0 : (j == 2'd1) ? 2'd2 : 2'd1;
        endcase
        return c;
    endfunction

    // corner pairs of the six quad edges: 01 02 03 12 13 23
    function automatic logic [1:0] edge_a(input logic [2:0] e);
        logic [1:0] c;
        c = 2'd0;
        case (e)
            3'd3, 3'd4: c = 2'd1;
            3'd5:       c = 2'd2;
            default:    c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] edge_b(input logic [2:0] e);
        logic [1:0] c;
        c = 2'd3;
        case (e)
            3'd0:       c = 2'd1;
            3'd1, 3'd3: c = 2'd2;
            default:    c = 2'd3;
        endcase
        return c;
    endfunction

endpackage

@@ design/depth_quad_triangulator.sv @@
// Top level: line store, quad sequencer and vertex/radius arithmetic.
// A sample with no quad returns to idle; a quad runs its setup and edge tests, passes over each
// skipped triangle slot, computes each vertex word and then the radius word; the output can stall it.
// Throughput: one sample at a time, the pace set by the triangle walk and the
// 32-step square root. Reset: synchronous, active low; counters, held samples and registers
// return to their reset values at once; the line store is not cleared.
module depth_quad_triangulator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dqt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dqt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_depth_valid,
    output logic                               o_depth_ready,
    input  logic [15:0]                        i_depth_sample,
    output logic                               o_rec_valid,
    input  logic                               i_rec_ready,
    output logic                               o_record_kind,
    output logic signed [31:0]                 o_pos_x,
    output logic signed [31:0]                 o_pos_y,
    output logic [15:0]                        o_pos_z,
    output logic [15:0]                        o_tex_u,
    output logic [15:0]                        o_tex_v,
    output logic [31:0]                        o_radius_out,
    output logic [dqt_pkg::ROW_W-1:0]          o_quad_row,
    output logic [dqt_pkg::COL_W-1:0]          o_quad_col,
    output logic                               o_last
);
    import dqt_pkg::*;

    // configuration
    logic [10:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [23:0] r_inv_fx, r_inv_fy, r_inv_w, r_inv_h;
    logic [15:0] r_ratio;
    logic [10:0] w_eff;
    logic [12:0] h_eff;

    // raster state
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [15:0]      r_left, r_ul, r_cur, r_above;
    logic [COL_W-1:0] r_acc_col;
    logic [ROW_W-1:0] r_acc_row;
    logic [15:0]      mem [MAX_WIDTH];

    // quad state
    t_state           r_state, n_state;
    logic [15:0]      r_d [4];
    logic [3:0]       r_sel;
    logic             r_v3;
    logic [5:0]       r_ok;
    logic [2:0]       r_e;
    logic [2:0]       r_slot;
    logic [1:0]       r_j;
    logic [1:0]       r_corner;
    logic             r_is_rad;
    logic [COL_W-1:0] r_qc;
    logic [ROW_W-1:0] r_qr;

    // arithmetic
    logic             r_negx, r_negy;
    logic [29:0]      r_zax, r_zay;
    logic [35:0]      r_tu;
    logic [37:0]      r_tv;
    logic [53:0]      r_px, r_py;
    logic [15:0]      r_tex_u, r_tex_v;
    logic [31:0]      r_magx, r_magy, r_posx, r_posy;
    logic [63:0]      r_sx, r_sy, r_sz, r_rem, r_res, r_bit;
    logic [4:0]       r_it;

    // output word
    logic             r_o_valid;

    logic depth_acc, load_out, out_free;
    assign depth_acc = i_depth_valid & o_depth_ready;
    assign out_free  = ~r_o_valid | i_rec_ready;

    // clamp geometry to the supported sizes
    always_comb begin
        if (r_frame_width < 11'd2)                  w_eff = 11'd2;
        else if (r_frame_width > 11'(MAX_WIDTH))    w_eff = 11'(MAX_WIDTH);
        else                                        w_eff = r_frame_width;
        if (r_frame_height < 13'd2)                 h_eff = 13'd2;
        else if (r_frame_height > 13'(MAX_HEIGHT))  h_eff = 13'(MAX_HEIGHT);
        else                                        h_eff = r_frame_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_inv_fx       <= RST_INV_FOCAL_X;
            r_inv_fy       <= RST_INV_FOCAL_Y;
            r_inv_w        <= RST_INV_WIDTH;
            r_inv_h        <= RST_INV_HEIGHT;
            r_ratio        <= RST_MAX_DIFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[12:0];
                CFG_INV_FOCAL_X:  r_inv_fx       <= i_cfg_data;
                CFG_INV_FOCAL_Y:  r_inv_fy       <= i_cfg_data;
                CFG_INV_WIDTH:    r_inv_w        <= i_cfg_data;
                CFG_INV_HEIGHT:   r_inv_h        <= i_cfg_data;
                CFG_MAX_DIFF:     r_ratio        <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // line store: read the old word above and write the new sample in one access
    always_ff @(posedge i_clk) begin
        if (depth_acc) begin
            r_above      <= mem[r_col];
            mem[r_col]   <= i_depth_sample;
        end
    end

    // raster counters advance at acceptance
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (depth_acc) begin
            if (col_inc >= (COL_W+1)'(w_eff)) begin
                r_col <= '0;
                r_row <= ((ROW_W+1)'(row_inc) >= (ROW_W+1)'(h_eff)) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    // quad classification from the four corners as they arrive
    logic [3:0]  nz;
    logic [2:0]  nz_cnt;
    logic [3:0]  sel_c;
    logic [15:0] diff03, diff12;
    always_comb begin
        nz     = {r_cur != 16'd0, r_left != 16'd0, r_above != 16'd0, r_ul != 16'd0};
        nz_cnt = 3'(nz[0]) + 3'(nz[1]) + 3'(nz[2]) + 3'(nz[3]);
        diff03 = (r_ul > r_cur) ? r_ul - r_cur : r_cur - r_ul;
        diff12 = (r_above > r_left) ? r_above - r_left : r_left - r_above;
        sel_c  = 4'b0000;
        if (nz_cnt == 3'd3)      sel_c = ~nz;
        else if (nz_cnt == 3'd4) sel_c = (diff03 > diff12) ? 4'b1001 : 4'b0110;
    end

    // edge test for the current edge counter
    logic [15:0] ea, eb, e_diff, e_max;
    logic [31:0] e_lim;
    logic        e_ok;
    always_comb begin
        ea     = r_d[edge_a(r_e)];
        eb     = r_d[edge_b(r_e)];
        e_diff = (ea > eb) ? ea - eb : eb - ea;
        e_max  = (ea > eb) ? ea : eb;
        e_lim  = r_ratio * e_max;
        e_ok   = {e_diff, 16'd0} < e_lim;
    end

    // a triangle survives when every edge not touching its opposite corner passes
    logic [3:0] keep;
    assign keep[0] = r_sel[0] & r_ok[3] & r_ok[4] & r_ok[5];
    assign keep[1] = r_sel[1] & r_ok[1] & r_ok[2] & r_ok[5];
    assign keep[2] = r_sel[2] & r_ok[0] & r_ok[2] & r_ok[4];
    assign keep[3] = r_sel[3] & r_ok[0] & r_ok[1] & r_ok[3];

    // vertex offsets for the first multiply
    logic [10:0]        vx;
    logic [12:0]        vy;
    logic signed [14:0] ox, oy;
    logic [14:0]        ax_w, ay_w;
    logic [15:0]        vz;
    always_comb begin
        vx   = {1'b0, r_qc} + 11'(r_corner[0]);
        vy   = {1'b0, r_qr} + 13'(r_corner[1]);
        ox   = $signed({2'b00, vx, 1'b0}) - $signed({4'b0000, w_eff});
        oy   = $signed({vy, 1'b0}) - $signed({2'b00, h_eff});
        ax_w = ox[14] ? 15'(-ox) : 15'(ox);
        ay_w = oy[14] ? 15'(-oy) : 15'(oy);
        vz   = r_d[r_corner];
    end

    // rounding of projections and texture coordinates
    logic [37:0] rx, ry;
    logic [36:0] tur, tvr;
    logic [15:0] tu_sat, tv_sat;
    logic [31:0] magx, magy;
    logic [63:0] root_try;
    always_comb begin
        rx  = 38'((55'(r_px) + 55'h1_0000) >> 17);
        ry  = 38'((55'(r_py) + 55'h1_0000) >> 17);
        if (r_negx) magx = (rx > 38'h8000_0000) ? 32'h8000_0000 : rx[31:0];
        else        magx = (rx > 38'h7FFF_FFFF) ? 32'h7FFF_FFFF : rx[31:0];
        if (r_negy) magy = (ry > 38'h8000_0000) ? 32'h8000_0000 : ry[31:0];
        else        magy = (ry > 38'h7FFF_FFFF) ? 32'h7FFF_FFFF : ry[31:0];
        tur    = 37'((37'(r_tu) + 37'd256) >> 9);
        tvr    = 37'((39'(r_tv) + 39'd256) >> 9);
        tu_sat = (tur > 37'd65535) ? 16'hFFFF : tur[15:0];
        if (tvr >= 37'd65536)  tv_sat = 16'd0;
        else if (tvr == 37'd0) tv_sat = 16'hFFFF;
        else                   tv_sat = 16'(17'h1_0000 - tvr[16:0]);
        root_try = r_res + r_bit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (depth_acc) n_state = S_LOAD;
            S_LOAD: n_state = (r_acc_row == '0 || r_acc_col == '0) ? S_IDLE : S_EDGE;
            S_EDGE: if (r_e == 3'd5) n_state = S_PICK;
            S_PICK: begin
                if (r_slot[2])              n_state = r_v3 ? S_MUL1 : S_EMIT;
                else if (keep[r_slot[1:0]]) n_state = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_RND;
            S_RND:  n_state = r_is_rad ? S_SQR : S_EMIT;
            S_SQR:  n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: if (r_it == 5'd31) n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = r_is_rad ? S_IDLE : S_PICK;
            default: n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_depth_ready = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE:  o_depth_ready = 1'b1;
            S_EMIT:  load_out      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // held samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ul   <= '0;
        end else if (r_state == S_LOAD) begin
            r_ul   <= r_above;
            r_left <= r_cur;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (depth_acc) begin
            r_cur     <= i_depth_sample;
            r_acc_col <= r_col;
            r_acc_row <= r_row;
        end
        unique case (r_state)
            S_LOAD: begin
                r_d[0] <= r_ul;
                r_d[1] <= r_above;
                r_d[2] <= r_left;
                r_d[3] <= r_cur;
                r_sel  <= sel_c;
                r_v3   <= nz_cnt >= 3'd3;
                r_qc   <= r_acc_col - 1'b1;
                r_qr   <= r_acc_row - 1'b1;
                r_e    <= '0;
                r_slot <= '0;
                r_j    <= '0;
            end
            S_EDGE: begin
                r_ok[r_e] <= e_ok;
                r_e       <= r_e + 1'b1;
            end
            S_PICK: begin
                if (r_slot[2]) begin
                    r_is_rad <= 1'b1;
                    r_corner <= 2'd0;
                    r_res    <= '0;
                end else if (keep[r_slot[1:0]]) begin
                    r_is_rad <= 1'b0;
                    r_corner <= tri_corner(r_slot[1:0], r_j);
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            S_MUL1: begin
                r_negx <= ox[14];
                r_negy <= oy[14];
                r_zax  <= vz * ax_w[13:0];
                r_zay  <= vz * ay_w[13:0];
                r_tu   <= {vx, 1'b1} * r_inv_w;
                r_tv   <= {vy, 1'b1} * r_inv_h;
            end
            S_MUL2: begin
                r_px    <= r_zax * r_inv_fx;
                r_py    <= r_zay * r_inv_fy;
                r_tex_u <= tu_sat;
                r_tex_v <= tv_sat;
            end
            S_RND: begin
                r_magx <= magx;
                r_magy <= magy;
                r_posx <= r_negx ? 32'(-magx) : magx;
                r_posy <= r_negy ? 32'(-magy) : magy;
            end
            S_SQR: begin
                r_sx <= r_magx * r_magx;
                r_sy <= r_magy * r_magy;
                r_sz <= {16'd0, 32'(r_d[0]) * 32'(r_d[0]), 16'd0};
            end
            S_SUM: begin
                r_rem <= r_sx + r_sy + r_sz;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
                r_it  <= '0;
            end
            S_ROOT: begin
                // one result bit a step
                if (r_rem >= root_try) begin
                    r_rem <= r_rem - root_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_it  <= r_it + 1'b1;
            end
            S_EMIT: begin
                if (out_free && !r_is_rad) begin
                    if (r_j == 2'd2) begin
                        r_j    <= '0;
                        r_slot <= r_slot + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output word register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)       r_o_valid <= 1'b0;
        else if (load_out)  r_o_valid <= 1'b1;
        else if (i_rec_ready) r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_record_kind <= r_is_rad ? KIND_RADIUS : KIND_VERTEX;
            o_pos_x       <= r_is_rad ? '0 : $signed(r_posx);
            o_pos_y       <= r_is_rad ? '0 : $signed(r_posy);
            o_pos_z       <= r_is_rad ? '0 : r_d[r_corner];
            o_tex_u       <= r_is_rad ? '0 : r_tex_u;
            o_tex_v       <= r_is_rad ? '0 : r_tex_v;
            o_radius_out  <= r_is_rad ? r_res[31:0] : '0;
            o_quad_row    <= r_qr;
            o_quad_col    <= r_qc;
            o_last        <= r_is_rad;
        end
    end

    assign o_rec_valid = r_o_valid;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the depth quad triangulator.
`timescale 1ns / 1ps

module tb_top;
    import dqt_pkg::*;

    // Allow for the slowest run: every quad at its full record count
    // and the longest stalls on both sides.
    localparam int CYCLE_LIMIT = 3000000;
    // Pipeline settle time once the last expected word has gone.
    localparam int SETTLE      = 120;

    // Expected output word, one per record.
    typedef struct packed {
        logic        kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] pz;
        logic [15:0] u;
        logic [15:0] v;
        logic [31:0] rad;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } t_quad_rec;

    // Corner order of the triangle opposite each corner.
    localparam int TRI_CORNER [4][3] = '{'{3, 1, 2}, '{0, 2, 3}, '{3, 1, 0}, '{0, 2, 1}};

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_depth_valid  = 1'b0;
    logic [15:0]           i_depth_sample = '0;
    logic                  i_rec_ready    = 1'b0;
    logic                  o_depth_ready;
    logic                  o_rec_valid;
    logic                  o_record_kind;
    logic signed [31:0]    o_pos_x;
    logic signed [31:0]    o_pos_y;
    logic [15:0]           o_pos_z;
    logic [15:0]           o_tex_u;
    logic [15:0]           o_tex_v;
    logic [31:0]           o_radius_out;
    logic [ROW_W-1:0]      o_quad_row;
    logic [COL_W-1:0]      o_quad_col;
    logic                  o_last;

    depth_quad_triangulator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_depth_valid  (i_depth_valid),
        .o_depth_ready  (o_depth_ready),
        .i_depth_sample (i_depth_sample),
        .o_rec_valid    (o_rec_valid),
        .i_rec_ready    (i_rec_ready),
        .o_record_kind  (o_record_kind),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_radius_out   (o_radius_out),
        .o_quad_row     (o_quad_row),
        .o_quad_col     (o_quad_col),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: our own copy of registers, line store and counters
    // ---------------------------------------------------------------
    logic [10:0] frame_w_reg;
    logic [12:0] frame_h_reg;
    logic [23:0] inv_fx_reg, inv_fy_reg, inv_w_reg, inv_h_reg;
    logic [15:0] ratio_reg;
    logic [15:0] row_store [MAX_WIDTH];
    logic [15:0] left_px, upper_left_px;
    int unsigned cur_col, cur_row;

    t_quad_rec   record_q [$];
    int          err_count  = 0;
    longint      cycle_cnt  = 0;
    bit          no_idle    = 1'b0;   // stretch with no gaps on either side
    int unsigned depth_base = 16'h0400;
    int          rx_stall   = 0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = frame_w_reg;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = frame_h_reg;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // z (Q8.8) * off2/2 * inv (Q0.24) -> Q16.16, rounded away from zero, saturated.
    function automatic logic [31:0] project_axis(input longint unsigned z, input longint off2,
                                                 input longint unsigned inv,
                                                 output longint unsigned mag);
        longint unsigned a, p, r;
        a = (off2 < 0) ? longint'(-off2) : longint'(off2);
        p = z * a * inv;
        r = (p + 64'd65536) >> 17;
        if (off2 < 0) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            mag = r;
            return 32'd0 - r[31:0];
        end
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        mag = r;
        return r[31:0];
    endfunction

    function automatic longint unsigned tex_raw(input int unsigned pos,
                                                input longint unsigned inv);
        longint unsigned p;
        p = longint'(2 * pos + 1) * inv;
        return (p + 64'd256) >> 9;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned res, bitv, v;
        v    = val;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic bit edge_within(input longint unsigned a, input longint unsigned b);
        longint unsigned diff, mx;
        diff = (a > b) ? a - b : b - a;
        mx   = (a > b) ? a : b;
        return (diff << 16) < longint'(ratio_reg) * mx;
    endfunction

    // Work out the records one accepted sample causes and advance the raster position.
    task automatic triangulate_sample(input logic [15:0] sample);
        int unsigned    w, h, col, row, qr, qc, vx, vy, nvalid, c;
        logic [15:0]    above;
        longint unsigned d [4];
        bit             pick [4];
        longint unsigned mx, my, zz, rad, diag_a, diag_b, tu, tv;
        t_quad_rec      rec;
        w     = eff_width();
        h     = eff_height();
        col   = cur_col;
        row   = cur_row;
        above = row_store[col];
        if (row > 0 && col > 0) begin
            qr = row - 1;
            qc = col - 1;
            d[0] = upper_left_px;
            d[1] = above;
            d[2] = left_px;
            d[3] = sample;
            nvalid = 0;
            for (int k = 0; k < 4; k++) begin
                pick[k] = 1'b0;
                if (d[k] > 0) nvalid++;
            end
            if (nvalid == 3) begin
                // one corner missing: take the triangle opposite it
                for (int k = 3; k >= 0; k--) if (d[k] == 0) c = k;
                pick[c] = 1'b1;
            end else if (nvalid == 4) begin
                // split along the diagonal with the smaller depth step
                diag_a = (d[0] > d[3]) ? d[0] - d[3] : d[3] - d[0];
                diag_b = (d[1] > d[2]) ? d[1] - d[2] : d[2] - d[1];
                if (diag_a > diag_b) begin
                    pick[0] = 1'b1;
                    pick[3] = 1'b1;
                end else begin
                    pick[1] = 1'b1;
                    pick[2] = 1'b1;
                end
            end
            for (int t = 0; t < 4; t++) begin
                if (pick[t] &&
                    edge_within(d[TRI_CORNER[t][0]], d[TRI_CORNER[t][1]]) &&
                    edge_within(d[TRI_CORNER[t][1]], d[TRI_CORNER[t][2]]) &&
                    edge_within(d[TRI_CORNER[t][2]], d[TRI_CORNER[t][0]])) begin
                    for (int j = 0; j < 3; j++) begin
                        c  = TRI_CORNER[t][j];
                        vx = qc + (c & 1);
                        vy = qr + (c >> 1);
                        rec      = '0;
                        rec.kind = KIND_VERTEX;
                        rec.px   = project_axis(d[c], 2 * longint'(vx) - longint'(w),
                                                inv_fx_reg, mx);
                        rec.py   = project_axis(d[c], 2 * longint'(vy) - longint'(h),
                                                inv_fy_reg, my);
                        rec.pz   = d[c][15:0];
                        tu       = tex_raw(vx, inv_w_reg);
                        rec.u    = (tu > 65535) ? 16'hFFFF : tu[15:0];
                        tv       = tex_raw(vy, inv_h_reg);
                        tv       = (tv >= 65536) ? 0 : 65536 - tv;
                        rec.v    = (tv > 65535) ? 16'hFFFF : tv[15:0];
                        rec.row  = qr[11:0];
                        rec.col  = qc[9:0];
                        record_q.insert(record_q.size(), rec);
                    end
                end
            end
            rad = 0;
            if (nvalid >= 3) begin
                zz = d[0] << 8;
                void'(project_axis(d[0], 2 * longint'(qc) - longint'(w), inv_fx_reg, mx));
                void'(project_axis(d[0], 2 * longint'(qr) - longint'(h), inv_fy_reg, my));
                rad = int_sqrt(mx * mx + my * my + zz * zz);
                if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
            end
            rec      = '0;
            rec.kind = KIND_RADIUS;
            rec.rad  = rad[31:0];
            rec.row  = qr[11:0];
            rec.col  = qc[9:0];
            rec.last = 1'b1;
            record_q.insert(record_q.size(), rec);
        end
        upper_left_px  = above;
        row_store[col] = sample;
        left_px        = sample;
        if (col + 1 >= w) begin
            cur_col = 0;
            cur_row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            cur_col = col + 1;
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Smooth surface with holes, jumps and the odd wild value.
    function automatic logic [15:0] next_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) depth_base = $urandom_range(16'h0040, 16'hF000);
        if (r < 12) return 16'h0000;
        if (r < 17) return 16'($urandom_range(0, 16'hFFFF));
        if (r < 19) return 16'hFFFF;
        if (r < 21) return 16'h0001;
        return 16'(depth_base + $urandom_range(0, depth_base / 16 + 1));
    endfunction

    // Send one depth word; return at the edge that accepts it, valid still high.
    task automatic send_depth(input logic [15:0] d);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_depth_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_depth_valid  <= 1'b1;
        i_depth_sample <= d;
        do @(posedge i_clk); while (!o_depth_ready);
        triangulate_sample(d);
    endtask

    // Hold the sender until every expected word has come, then let the block settle.
    task automatic drain_records();
        i_depth_valid <= 1'b0;
        while (record_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  frame_w_reg = val[10:0];
            CFG_FRAME_HEIGHT: frame_h_reg = val[12:0];
            CFG_INV_FOCAL_X:  inv_fx_reg  = val;
            CFG_INV_FOCAL_Y:  inv_fy_reg  = val;
            CFG_INV_WIDTH:    inv_w_reg   = val;
            CFG_INV_HEIGHT:   inv_h_reg   = val;
            CFG_MAX_DIFF:     ratio_reg   = val[15:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Finish the current frame so a wider row never reads unwritten store entries.
    task automatic new_geometry(input logic [23:0] w, input logic [23:0] h);
        while (cur_row != 0 || cur_col != 0) send_depth(next_depth());
        drain_records();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Hand-picked 3x3 frames: full quads on either diagonal, a missing corner,
    // sparse quads, an edge over the ratio and the depth extremes.
    task automatic test_directed();
        logic [15:0] frame_a [9] = '{16'h0100, 16'h0100, 16'h012C,
                                     16'h0100, 16'h0104, 16'h0000,
                                     16'h0000, 16'h0000, 16'h0100};
        logic [15:0] frame_b [9] = '{16'hFFFF, 16'h0001, 16'hFFFF,
                                     16'h0001, 16'hFFFF, 16'hFFFF,
                                     16'h0000, 16'hFFFF, 16'hFFFF};
        new_geometry(24'd3, 24'd3);
        foreach (frame_a[k]) send_depth(frame_a[k]);
        drain_records();
        write_reg(CFG_MAX_DIFF, 24'h00FFFF);
        foreach (frame_b[k]) send_depth(frame_b[k]);
        drain_records();
    endtask

    // Register extremes: clamped sizes, reciprocals at both ends, a widest row cut
    // short, the tallest frame, and upper data bits that must be dropped.
    task automatic test_register_extremes();
        new_geometry(24'd0, 24'd0);
        write_reg(CFG_INV_FOCAL_X, 24'hFFFFFF);
        write_reg(CFG_INV_FOCAL_Y, 24'hFFFFFF);
        write_reg(CFG_INV_WIDTH,   24'hFFFFFF);
        write_reg(CFG_INV_HEIGHT,  24'hFFFFFF);
        write_reg(CFG_MAX_DIFF,    24'hFF0000);
        repeat (12) send_depth(next_depth());
        drain_records();
        write_reg(CFG_MAX_DIFF, 24'h12FFFF);
        repeat (12) send_depth(next_depth());
        new_geometry(24'hFFF7FF, 24'd2);
        write_reg(CFG_INV_FOCAL_X, 24'd1);
        write_reg(CFG_INV_FOCAL_Y, 24'd1);
        write_reg(CFG_INV_WIDTH,   24'd1);
        write_reg(CFG_INV_HEIGHT,  24'd1);
        no_idle = 1'b1;
        repeat (20) send_depth(next_depth());
        no_idle = 1'b0;
        // narrow the row under the column counter: the row ends at the next word
        drain_records();
        write_reg(CFG_FRAME_WIDTH, 24'd2);
        repeat (6) send_depth(next_depth());
        new_geometry(24'd2, 24'h1FFF);
        write_reg(CFG_INV_FOCAL_Y, RST_INV_FOCAL_Y);
        write_reg(CFG_INV_HEIGHT,  24'd4096);
        repeat (20) send_depth(next_depth());
        // shrink the frame under the counters: the frame ends when the current row does
        drain_records();
        write_reg(CFG_FRAME_HEIGHT, 24'd3);
        repeat (10) send_depth(next_depth());
    endtask

    // Random phases over small frames with random calibration; one phase runs
    // without idling and one pauses the sender until everything is out.
    task automatic test_random_frames();
        for (int ph = 0; ph < 4; ph++) begin
            new_geometry(24'($urandom_range(2, 9)), 24'($urandom_range(2, 6)));
            write_reg(CFG_INV_FOCAL_X, (ph % 2) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                : 24'($urandom_range(1000, 200000)));
            write_reg(CFG_INV_FOCAL_Y, (ph % 2) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                : 24'($urandom_range(1000, 200000)));
            write_reg(CFG_INV_WIDTH,  24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(CFG_INV_HEIGHT, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(CFG_MAX_DIFF,   (ph == 3) ? 24'($urandom_range(0, 16'hFFFF))
                                                : 24'($urandom_range(3000, 40000)));
            no_idle = (ph == 2);
            for (int k = 0; k < 36; k++) begin
                if (ph == 1 && k == 18) drain_records();
                send_depth(next_depth());
            end
            no_idle = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and the word-by-word check
    // ---------------------------------------------------------------
    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want != got)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            i_rec_ready <= 1'b0;
            rx_stall    <= rx_stall - 1;
        end else begin
            i_rec_ready <= 1'b1;
            rx_stall    <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        t_quad_rec want;
        if (i_rst_n && o_rec_valid && i_rec_ready) begin
            if (record_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual kind %0b row %0d col %0d",
                         $time, o_record_kind, o_quad_row, o_quad_col);
                err_count++;
            end else begin
                want = record_q.pop_front();
                if (want != {o_record_kind, o_pos_x, o_pos_y, o_pos_z, o_tex_u, o_tex_v,
                             o_radius_out, o_quad_row, o_quad_col, o_last}) begin
                    err_count++;
                    report_field("record_kind", want.kind, o_record_kind);
                    report_field("pos_x",       want.px,   $unsigned(o_pos_x));
                    report_field("pos_y",       want.py,   $unsigned(o_pos_y));
                    report_field("pos_z",       want.pz,   o_pos_z);
                    report_field("tex_u",       want.u,    o_tex_u);
                    report_field("tex_v",       want.v,    o_tex_v);
                    report_field("radius_out",  want.rad,  o_radius_out);
                    report_field("quad_row",    want.row,  o_quad_row);
                    report_field("quad_col",    want.col,  o_quad_col);
                    report_field("last",        want.last, o_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        frame_w_reg   = RST_FRAME_WIDTH;
        frame_h_reg   = RST_FRAME_HEIGHT;
        inv_fx_reg    = RST_INV_FOCAL_X;
        inv_fy_reg    = RST_INV_FOCAL_Y;
        inv_w_reg     = RST_INV_WIDTH;
        inv_h_reg     = RST_INV_HEIGHT;
        ratio_reg     = RST_MAX_DIFF;
        left_px       = '0;
        upper_left_px = '0;
        cur_col       = 0;
        cur_row       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_random_frames();

        drain_records();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ depth_quad_triangulator.f @@
design/dqt_pkg.sv
design/depth_quad_triangulator.sv
tb/tb_top.sv
